// ----- rtl/core/lazy_range_add_range_sum_tree_assert.svh -----
// Assertion macros used by lrst_ctrl. Each expects clk and rst_n in scope.
`ifndef LAZY_RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH
`define LAZY_RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH

// Same-cycle implication.
`define LRST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LRST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lrst_pkg.sv -----
`timescale 1ns / 1ps
package lrst_pkg;

    localparam int LEAVES    = 1024;
    localparam int DATA_W    = 64;
    localparam int VAL_W     = 32;
    localparam int LO_W      = 10;
    localparam int HI_W      = 11;
    localparam int KIND_W    = 2;
    // Holds any position count 0..LEAVES.
    localparam int IDX_W     = $clog2(LEAVES + 1);
    // Walk index; an upward walk may step past LEAVES by up to LEAVES.
    localparam int X_W       = IDX_W + 1;
    localparam int RAM_DEPTH = LEAVES + 1;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [KIND_W-1:0] REQ_SET = 2'd0;
    localparam logic [KIND_W-1:0] REQ_ADD = 2'd1;
    localparam logic [KIND_W-1:0] REQ_SUM = 2'd2;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic q_start;
        logic upper;
        logic q_step;
        logic mul_en;
        logic mul_q;
        logic p_save;
        logic amt_load;
        logic u_start;
        logic u_write;
        logic res_load;
    } lrst_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              range_ok;
        logic              x_zero;
        logic              x_last;
        logic              x_over;
        logic              hi_full;
    } lrst_stat_t;

endpackage

// ----- rtl/core/lrst_req_if.sv -----
`timescale 1ns / 1ps
interface lrst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [9:0]  range_lo;
    logic [10:0] range_hi;
    logic [31:0] value;

    modport source (output valid, req_type, range_lo, range_hi, value, input ready);
    modport sink (input valid, req_type, range_lo, range_hi, value, output ready);
endinterface

// ----- rtl/core/lrst_res_if.sv -----
`timescale 1ns / 1ps
interface lrst_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] range_sum;

    modport source (output valid, range_sum, input ready);
    modport sink (input valid, range_sum, output ready);
endinterface

// ----- rtl/core/lrst_ram.sv -----
`timescale 1ns / 1ps
module lrst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/core/lrst_dp.sv -----
`timescale 1ns / 1ps
module lrst_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lrst_pkg::lrst_cmd_t         cmd,
    output lrst_pkg::lrst_stat_t        stat,
    input  logic [lrst_pkg::KIND_W-1:0] req_type,
    input  logic [lrst_pkg::LO_W-1:0]   range_lo,
    input  logic [lrst_pkg::HI_W-1:0]   range_hi,
    input  logic [lrst_pkg::VAL_W-1:0]  value,
    output logic [lrst_pkg::DATA_W-1:0] range_sum
);
    import lrst_pkg::*;

    logic [X_W-1:0]    x_reg, x_next;
    logic [KIND_W-1:0] kind_reg;
    logic [IDX_W-1:0]  lo_reg, hi_reg, hi_in, bound;
    logic [X_W-1:0]    xq_reg;
    logic [DATA_W-1:0] v_reg, acc1_reg, acc2_reg, prod_reg, pa_reg, pb_reg;
    logic [DATA_W-1:0] amt_reg, d1_reg, d2_reg, res_reg;
    logic [DATA_W-1:0] rd1, rd2, wd1, wd2, mul_a;
    logic [X_W-1:0]    mul_b, x_low;
    logic [DATA_W+X_W-1:0] prod_full;
    logic              ram_we;

    // The two stores hold the Fenwick tables of a range-add, range-sum pair:
    // prefix(x) = x * sum(B1[1..x]) - sum(B2[1..x]).
    lrst_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_ram_b1 (
        .clk(clk), .we(ram_we), .waddr(x_reg[RAM_AW-1:0]), .wdata(wd1),
        .raddr(x_reg[RAM_AW-1:0]), .rdata(rd1)
    );
    lrst_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_ram_b2 (
        .clk(clk), .we(ram_we), .waddr(x_reg[RAM_AW-1:0]), .wdata(wd2),
        .raddr(x_reg[RAM_AW-1:0]), .rdata(rd2)
    );

    assign ram_we = cmd.clr_step | cmd.u_write;
    assign wd1    = cmd.clr_step ? '0 : rd1 + d1_reg;
    assign wd2    = cmd.clr_step ? '0 : rd2 + d2_reg;
    assign x_low  = x_reg & (~x_reg + X_W'(1));
    assign hi_in  = (X_W'(range_hi) > X_W'(LEAVES)) ? IDX_W'(LEAVES) : IDX_W'(range_hi);
    assign bound  = cmd.upper ? hi_reg : lo_reg;
    assign mul_a  = cmd.mul_q ? acc1_reg : amt_reg;
    assign mul_b  = cmd.mul_q ? xq_reg : X_W'(bound);
    assign prod_full = mul_a * mul_b;

    always_comb
    begin
        x_next = x_reg;
        priority if (cmd.clr_step)
        begin
            x_next = x_reg + X_W'(1);
        end
        else if (cmd.q_start)
        begin
            x_next = X_W'(bound);
        end
        else if (cmd.q_step)
        begin
            x_next = x_reg & (x_reg - X_W'(1));
        end
        else if (cmd.u_start)
        begin
            x_next = X_W'(bound) + X_W'(1);
        end
        else if (cmd.u_write)
        begin
            x_next = x_reg + x_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req_type;
            lo_reg   <= IDX_W'(range_lo);
            hi_reg   <= (req_type == REQ_SET) ? IDX_W'(range_lo) + IDX_W'(1) : hi_in;
            v_reg    <= {{(DATA_W-VAL_W){value[VAL_W-1]}}, value};
        end
        if (cmd.q_start)
        begin
            xq_reg   <= X_W'(bound);
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        if (cmd.q_step)
        begin
            acc1_reg <= acc1_reg + rd1;
            acc2_reg <= acc2_reg + rd2;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_full[DATA_W-1:0];
        end
        if (cmd.p_save)
        begin
            pb_reg <= pa_reg;
            pa_reg <= prod_reg - acc2_reg;
        end
        if (cmd.amt_load)
        begin
            // A set becomes a one-position add of the difference to the old value.
            amt_reg <= (kind_reg == REQ_SET) ? v_reg - pb_reg + pa_reg : v_reg;
        end
        if (cmd.u_start)
        begin
            d1_reg <= cmd.upper ? -amt_reg : amt_reg;
            d2_reg <= cmd.upper ? -prod_reg : prod_reg;
        end
        if (cmd.res_load)
        begin
            res_reg <= stat.range_ok ? pb_reg - pa_reg : '0;
        end
    end

    assign stat.kind     = kind_reg;
    assign stat.range_ok = (lo_reg < hi_reg) && (X_W'(lo_reg) < X_W'(LEAVES));
    assign stat.x_zero   = (x_reg == '0);
    assign stat.x_last   = (x_reg == X_W'(LEAVES));
    assign stat.x_over   = (x_reg > X_W'(LEAVES));
    assign stat.hi_full  = (X_W'(hi_reg) >= X_W'(LEAVES));
    assign range_sum     = res_reg;
endmodule

// ----- rtl/core/lrst_ctrl.sv -----
`timescale 1ns / 1ps
`include "lazy_range_add_range_sum_tree_assert.svh"
module lrst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lrst_pkg::lrst_cmd_t  cmd,
    input  lrst_pkg::lrst_stat_t stat
);
    import lrst_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_QSTART = 4'd3;
    localparam logic [3:0] S_QRD    = 4'd4;
    localparam logic [3:0] S_QACC   = 4'd5;
    localparam logic [3:0] S_QMUL   = 4'd6;
    localparam logic [3:0] S_QSUB   = 4'd7;
    localparam logic [3:0] S_AMT    = 4'd8;
    localparam logic [3:0] S_UMUL   = 4'd9;
    localparam logic [3:0] S_USTART = 4'd10;
    localparam logic [3:0] S_URD    = 4'd11;
    localparam logic [3:0] S_UWR    = 4'd12;
    localparam logic [3:0] S_RES    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       second_reg, second_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.x_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                second_next = 1'b0;
                unique case (stat.kind)
                    REQ_SUM: state_next = stat.range_ok ? S_QSTART : S_RES;
                    REQ_SET: state_next = stat.range_ok ? S_QSTART : S_IDLE;
                    REQ_ADD: state_next = stat.range_ok ? S_AMT : S_IDLE;
                    default: state_next = S_IDLE;
                endcase
            end
            S_QSTART:
            begin
                cmd.q_start = 1'b1;
                cmd.upper   = !second_reg;
                state_next  = S_QRD;
            end
            S_QRD:
            begin
                state_next = stat.x_zero ? S_QMUL : S_QACC;
            end
            S_QACC:
            begin
                cmd.q_step = 1'b1;
                state_next = S_QRD;
            end
            S_QMUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_q  = 1'b1;
                state_next = S_QSUB;
            end
            S_QSUB:
            begin
                cmd.p_save = 1'b1;
                if (!second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = S_QSTART;
                end
                else
                begin
                    state_next = (stat.kind == REQ_SUM) ? S_RES : S_AMT;
                end
            end
            S_AMT:
            begin
                cmd.amt_load = 1'b1;
                second_next  = 1'b0;
                state_next   = S_UMUL;
            end
            S_UMUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.upper  = second_reg;
                state_next = S_USTART;
            end
            S_USTART:
            begin
                cmd.u_start = 1'b1;
                cmd.upper   = second_reg;
                state_next  = S_URD;
            end
            S_URD:
            begin
                if (!stat.x_over)
                begin
                    state_next = S_UWR;
                end
                else if (!second_reg && !stat.hi_full)
                begin
                    second_next = 1'b1;
                    state_next  = S_UMUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_UWR:
            begin
                cmd.u_write = 1'b1;
                state_next  = S_URD;
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `LRST_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_reg == S_DISP, "accepted beat not dispatched")
    `LRST_ASSERT_NEXT(a_res_waits, state_reg == S_RES && out_valid_reg && !out_ready, state_reg == S_RES && out_valid_reg, "result overwrote a waiting beat")
    `LRST_ASSERT_NOW(a_write_in_range, cmd.u_write, !stat.x_over && !stat.x_zero, "table write outside the stored range")
endmodule

// ----- rtl/core/lazy_range_add_range_sum_tree.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Payload                                   Beat produces
// req      in   req_type, range_lo, range_hi, value       one request
// res      out  range_sum                                 one result per sum request
//
// After reset a clearing pass zeroes both tables; req is not ready then.
// A query pass reads at most log2(LEAVES) entries, an update pass writes at most
// log2(LEAVES)+1 entries. A sum makes two query passes, an add up to two update
// passes, a set both. A finished sum waits in the output register while the next
// request is taken; a later sum holds in its last cycle until that beat leaves.
module lazy_range_add_range_sum_tree (
    input  logic       clk,
    input  logic       rst_n,
    lrst_req_if.sink   req,
    lrst_res_if.source res
);
    import lrst_pkg::*;

    lrst_cmd_t  cmd;
    lrst_stat_t stat;

    lrst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(res.valid), .out_ready(res.ready),
        .cmd(cmd), .stat(stat)
    );

    lrst_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .req_type(req.req_type), .range_lo(req.range_lo),
        .range_hi(req.range_hi), .value(req.value),
        .range_sum(res.range_sum)
    );
endmodule
